>>> design/html_entity_escape_stream_defines.svh
// Assertion macros shared by the escaper modules.
`ifndef HTML_ENTITY_ESCAPE_STREAM_DEFINES_SVH
`define HTML_ENTITY_ESCAPE_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/hes_pkg.sv
// Shared types and constants of the HTML entity escaper.
`timescale 1ns / 1ps

package hes_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxRun     = 6;
  localparam int unsigned LenW       = 3;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] CtrlTop = 8'h20;
  localparam logic [7:0] HighTop = 8'h80;

  // Entity texts, first byte in the leftmost lane.
  localparam logic [8*MaxRun-1:0] EntAmp  = {"&amp;", 8'h00};
  localparam logic [8*MaxRun-1:0] EntLt   = {"&lt;", 16'h0000};
  localparam logic [8*MaxRun-1:0] EntGt   = {"&gt;", 16'h0000};
  localparam logic [8*MaxRun-1:0] EntQuot = "&quot;";
  localparam logic [8*MaxRun-1:0] EntApos = "&apos;";
  localparam logic [15:0]         DecHead = "&#";

  typedef enum logic [0:0] {
    CfgUtf8Through    = 1'b0,
    CfgVerbatimPrefix = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic utf8_through;
    logic verbatim_prefix;
  } cfg_t;

  // One escaped run: up to six bytes, its length and the end-of-string mark.
  typedef struct packed {
    logic [0:MaxRun-1][7:0] bytes;
    logic [LenW-1:0]        len;
    logic                   str_end;
  } run_t;

endpackage

>>> design/html_entity_escape_stream.sv
// Top level of the streaming HTML entity escaper.
`timescale 1ns / 1ps

// Streaming HTML entity escaper. Each input request carries one byte and a
// string-end mark; it produces one to six output bytes (&amp; &lt; &gt; &quot;
// &apos;, decimal &#N; for control bytes other than tab and newline and, unless
// utf8_through is set, for bytes 0x80 and above; everything else raw). run_last
// marks the last byte of each run, string_done the last byte of a string's final
// input. With verbatim_prefix set, the leading bytes of each string up to the
// first whitespace, NUL or special character pass raw. Rate: the front end takes
// one input per cycle while the queue has room and turns it into a run in the
// same cycle; the back end sends one output byte per cycle while out_ready_i is
// high, so a run of N bytes occupies the output for N transfers. A queue of
// QueueDepth runs (default 4) sits between the two, so inputs keep flowing
// until it fills; sustained throughput is one input per cycle for raw bytes. Each
// run is written into the queue before it is output. Configuration writes take
// effect on the next input and must be made while the block is idle.
module html_entity_escape_stream #(
  parameter int unsigned QueueDepth = hes_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_done_o
);
  import hes_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push_valid, push_ready, head_valid, pop;
  run_t push_run, head_run;

  // Configuration registers, one bit each.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgUtf8Through:    cfg_d.utf8_through    = cfg_wdata_i;
        CfgVerbatimPrefix: cfg_d.verbatim_prefix = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Classify and build the escaped run for each accepted byte.
  hes_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .string_end_i (string_end_i),
    .in_ready_o   (in_ready_o),
    .push_valid_o (push_valid),
    .push_run_o   (push_run),
    .push_ready_i (push_ready)
  );

  // Decoupling queue; its entries also act as the output register.
  hes_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_run_i   (push_run),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_run_o   (head_run),
    .pop_i        (pop)
  );

  // Walk the head run one byte per output request.
  hes_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_run_i    (head_run),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

>>> design/hes_front.sv
// Front end: takes input bytes, tracks the raw prefix and builds escaped runs.
`timescale 1ns / 1ps

module hes_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hes_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          string_end_i,
  output logic          in_ready_o,
  output logic          push_valid_o,
  output hes_pkg::run_t push_run_o,
  input  logic          push_ready_i
);
  import hes_pkg::*;

  logic       in_prefix_q, in_prefix_d;
  logic       accept;
  logic       is_special, is_break, prefix_now, as_decimal;
  logic [1:0] hund;
  logic [7:0] rem8;
  logic [6:0] rem;
  logic [14:0] prod;
  logic [3:0] tens;
  logic [6:0] tens_x10;
  logic [6:0] ones7;
  logic [7:0] d2, d1, d0;
  run_t       run;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign is_special = (in_byte_i == ChAmp) || (in_byte_i == ChLt) || (in_byte_i == ChGt) ||
                      (in_byte_i == ChQuot) || (in_byte_i == ChApos);
  assign is_break   = (in_byte_i == ChSpace) || (in_byte_i == ChNul) || is_special ||
                      ((in_byte_i >= ChTab) && (in_byte_i <= ChCr));
  assign prefix_now = in_prefix_q && !is_break;

  // Decimal digits: hundreds by compare, tens by reciprocal multiply (205/2048).
  always_comb begin
    hund     = (in_byte_i >= 8'd200) ? 2'd2 : (in_byte_i >= 8'd100) ? 2'd1 : 2'd0;
    rem8     = in_byte_i - ((hund == 2'd2) ? 8'd200 : (hund == 2'd1) ? 8'd100 : 8'd0);
    rem      = rem8[6:0];
    prod     = {8'b0, rem} * 15'd205;
    tens     = prod[14:11];
    tens_x10 = {tens, 3'b000} - {3'b000, tens} + {2'b00, tens, 1'b0} + {3'b000, tens};
    ones7    = rem - tens_x10;
    d2       = ChZero + {6'b0, hund};
    d1       = ChZero + {4'b0, tens};
    d0       = ChZero + {4'b0, ones7[3:0]};
  end

  assign as_decimal = (in_byte_i < HighTop) ? (in_byte_i < CtrlTop) : !cfg_i.utf8_through;

  always_comb begin
    run          = '0;
    run.str_end  = string_end_i;
    run.len      = LenW'(1);
    run.bytes[0] = in_byte_i;
    if (!(cfg_i.verbatim_prefix && prefix_now)) begin
      case (in_byte_i)
        ChAmp: begin
          run.bytes = EntAmp;
          run.len   = LenW'(5);
        end
        ChLt: begin
          run.bytes = EntLt;
          run.len   = LenW'(4);
        end
        ChGt: begin
          run.bytes = EntGt;
          run.len   = LenW'(4);
        end
        ChQuot: begin
          run.bytes = EntQuot;
          run.len   = LenW'(6);
        end
        ChApos: begin
          run.bytes = EntApos;
          run.len   = LenW'(6);
        end
        ChTab, ChNl: begin
          run.len = LenW'(1);
        end
        default: begin
          if (as_decimal) begin
            if (hund != 2'd0) begin
              run.bytes = {DecHead, d2, d1, d0, ChSemi};
              run.len   = LenW'(6);
            end else if (tens != 4'd0) begin
              run.bytes = {DecHead, d1, d0, ChSemi, 8'h00};
              run.len   = LenW'(5);
            end else begin
              run.bytes = {DecHead, d0, ChSemi, 16'h0000};
              run.len   = LenW'(4);
            end
          end
        end
      endcase
    end
  end

  assign push_run_o = run;

  // Prefix flag: cleared by a break byte, set again after each string end.
  always_comb begin
    in_prefix_d = in_prefix_q;
    if (accept) begin
      if (string_end_i) begin
        in_prefix_d = 1'b1;
      end else if (is_break) begin
        in_prefix_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_prefix_q <= 1'b1;
    end else begin
      in_prefix_q <= in_prefix_d;
    end
  end

endmodule

>>> design/hes_queue.sv
// Small register queue of escaped runs between front and back end.
`timescale 1ns / 1ps
`include "html_entity_escape_stream_defines.svh"

module hes_queue #(
  parameter int unsigned Depth = hes_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  hes_pkg::run_t push_run_i,
  output logic          push_ready_o,
  output logic          head_valid_o,
  output hes_pkg::run_t head_run_o,
  input  logic          pop_i
);
  import hes_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_run_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_run_i;
    end
  end

  `HES_ASSERT_NEXT(a_fill_up, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + 1'b1)
  `HES_ASSERT_NEXT(a_drain, clk_i, rst_ni, pop && !push, count_q == $past(count_q) - 1'b1)
  `HES_ASSERT_NEXT(a_head_kept, clk_i, rst_ni, head_valid_o && !pop,
                   head_valid_o && (rd_ptr_q == $past(rd_ptr_q)))

endmodule

>>> design/hes_back.sv
// Back end: serializes the head run into output bytes with end flags.
`timescale 1ns / 1ps
`include "html_entity_escape_stream_defines.svh"

module hes_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  hes_pkg::run_t head_run_i,
  output logic          pop_o,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          string_done_o,
  input  logic          out_ready_i
);
  import hes_pkg::*;

  logic [LenW-1:0] idx_q, idx_d;
  logic            last, fire;

  assign last          = (idx_q == (head_run_i.len - LenW'(1)));
  assign fire          = head_valid_i && out_ready_i;
  assign pop_o         = fire && last;
  assign out_valid_o   = head_valid_i;
  assign out_byte_o    = head_run_i.bytes[idx_q];
  assign run_last_o    = last;
  assign string_done_o = last && head_run_i.str_end;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `HES_ASSERT_NOW(a_idx_in_run, clk_i, rst_ni, head_valid_i, idx_q < head_run_i.len)
  `HES_ASSERT_NEXT(a_step_on, clk_i, rst_ni, fire && !last,
                   head_valid_i && (idx_q == $past(idx_q) + 1'b1))
  `HES_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_byte_o))

endmodule
